[design/iruop_pkg.sv]
`default_nettype none

package iruop_pkg;

  localparam int unsigned DataWidth = 64;

  // Dense operation numbering
  typedef enum logic [5:0] {
    KIND_NOT1           = 6'd0,
    KIND_NOT8           = 6'd1,
    KIND_NOT16          = 6'd2,
    KIND_NOT32          = 6'd3,
    KIND_NOT64          = 6'd4,
    KIND_NOTV128        = 6'd5,
    KIND_1UTO8          = 6'd6,
    KIND_1UTO32         = 6'd7,
    KIND_1UTO64         = 6'd8,
    KIND_1STO8          = 6'd9,
    KIND_1STO16         = 6'd10,
    KIND_1STO32         = 6'd11,
    KIND_1STO64         = 6'd12,
    KIND_8STO16         = 6'd13,
    KIND_8STO32         = 6'd14,
    KIND_8STO64         = 6'd15,
    KIND_8UTO16         = 6'd16,
    KIND_8UTO32         = 6'd17,
    KIND_8UTO64         = 6'd18,
    KIND_16STO32        = 6'd19,
    KIND_16STO64        = 6'd20,
    KIND_16UTO32        = 6'd21,
    KIND_16UTO64        = 6'd22,
    KIND_32STO64        = 6'd23,
    KIND_32UTO64        = 6'd24,
    KIND_32TO1          = 6'd25,
    KIND_64TO1          = 6'd26,
    KIND_32TO8          = 6'd27,
    KIND_64TO8          = 6'd28,
    KIND_32TO16         = 6'd29,
    KIND_64TO16         = 6'd30,
    KIND_64TO32         = 6'd31,
    KIND_V128TO32       = 6'd32,
    KIND_V128TO64       = 6'd33,
    KIND_128TO64        = 6'd34,
    KIND_16HITO8        = 6'd35,
    KIND_32HITO16       = 6'd36,
    KIND_64HITO32       = 6'd37,
    KIND_128HITO64      = 6'd38,
    KIND_V128HITO64     = 6'd39,
    KIND_32UTOV128      = 6'd40,
    KIND_64UTOV128      = 6'd41,
    KIND_CLZ32          = 6'd42,
    KIND_CLZ64          = 6'd43,
    KIND_CTZ32          = 6'd44,
    KIND_CTZ64          = 6'd45,
    KIND_GET_MSBS8X16   = 6'd46
  } kind_t;

  // Leading zero count by halving search; an all-zero word gives 64.
  function automatic logic [6:0] lead_zeros64(input logic [63:0] value);
    logic [63:0] x;
    logic [6:0]  n;
    x = value;
    n = 7'd0;
    if (x[63:32] == 32'd0) begin n = n + 7'd32; x = x << 32; end
    if (x[63:48] == 16'd0) begin n = n + 7'd16; x = x << 16; end
    if (x[63:56] == 8'd0)  begin n = n + 7'd8;  x = x << 8;  end
    if (x[63:60] == 4'd0)  begin n = n + 7'd4;  x = x << 4;  end
    if (x[63:62] == 2'd0)  begin n = n + 7'd2;  x = x << 2;  end
    if (!x[63])            begin n = n + 7'd1;  x = x << 1;  end
    if (!x[63])            n = n + 7'd1;
    return n;
  endfunction

  function automatic logic [63:0] bit_reverse64(input logic [63:0] value);
    logic [63:0] r;
    for (int i = 0; i < DataWidth; i++) begin
      r[i] = value[DataWidth-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ir_unary_integer_op_unit.sv]
`default_nettype none

// Unary integer IR operation unit. A request (kind, operand_lo, operand_hi)
// is taken whenever start is high; busy is always low, so one request may be
// issued every cycle. The result appears on result_lo, result_hi and
// unsupported with done high once the request has passed through the input
// register and the operation logic into the result register. The receiver
// cannot hold results off, and each result is shown for one cycle only.
// Codes above the last defined operation give zero results with
// unsupported set.
module ir_unary_integer_op_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [5:0]                        kind,
  input  wire logic [iruop_pkg::DataWidth-1:0]   operand_lo,
  input  wire logic [iruop_pkg::DataWidth-1:0]   operand_hi,
  output logic                                   done,
  output logic [iruop_pkg::DataWidth-1:0]        result_lo,
  output logic [iruop_pkg::DataWidth-1:0]        result_hi,
  output logic                                   unsupported
);
  import iruop_pkg::*;

  logic                 in_valid;
  logic [5:0]           in_kind;
  logic [DataWidth-1:0] in_lo;
  logic [DataWidth-1:0] in_hi;

  logic [DataWidth-1:0] result_lo_next;
  logic [DataWidth-1:0] result_hi_next;
  logic                 unsupported_next;

  logic [6:0]  clz32_cnt, clz64_cnt, ctz32_cnt, ctz64_cnt;
  logic [15:0] msbs;

  assign busy = 1'b0;

  // Pad with ones so a zero operand counts to the operand width
  assign clz32_cnt = lead_zeros64({in_lo[31:0], 32'hFFFF_FFFF});
  assign clz64_cnt = lead_zeros64(in_lo);
  assign ctz32_cnt = lead_zeros64(bit_reverse64({32'hFFFF_FFFF, in_lo[31:0]}));
  assign ctz64_cnt = lead_zeros64(bit_reverse64(in_lo));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      msbs[i]     = in_lo[8*i+7];
      msbs[i + 8] = in_hi[8*i+7];
    end
  end

  always_comb begin
    result_lo_next   = '0;
    result_hi_next   = '0;
    unsupported_next = 1'b0;
    unique case (kind_t'(in_kind))
      KIND_NOT1:   result_lo_next = {63'd0, ~in_lo[0]};
      KIND_NOT8:   result_lo_next = {56'd0, ~in_lo[7:0]};
      KIND_NOT16:  result_lo_next = {48'd0, ~in_lo[15:0]};
      KIND_NOT32:  result_lo_next = {32'd0, ~in_lo[31:0]};
      KIND_NOT64:  result_lo_next = ~in_lo;
      KIND_NOTV128: begin
        result_lo_next = ~in_lo;
        result_hi_next = ~in_hi;
      end
      KIND_1UTO8, KIND_1UTO32, KIND_1UTO64, KIND_32TO1, KIND_64TO1:
        result_lo_next = {63'd0, in_lo[0]};
      KIND_1STO8:  result_lo_next = {56'd0, {8{in_lo[0]}}};
      KIND_1STO16: result_lo_next = {48'd0, {16{in_lo[0]}}};
      KIND_1STO32: result_lo_next = {32'd0, {32{in_lo[0]}}};
      KIND_1STO64: result_lo_next = {64{in_lo[0]}};
      KIND_8STO16: result_lo_next = {48'd0, {8{in_lo[7]}}, in_lo[7:0]};
      KIND_8STO32: result_lo_next = {32'd0, {24{in_lo[7]}}, in_lo[7:0]};
      KIND_8STO64: result_lo_next = {{56{in_lo[7]}}, in_lo[7:0]};
      KIND_8UTO16, KIND_8UTO32, KIND_8UTO64, KIND_32TO8, KIND_64TO8:
        result_lo_next = {56'd0, in_lo[7:0]};
      KIND_16STO32: result_lo_next = {32'd0, {16{in_lo[15]}}, in_lo[15:0]};
      KIND_16STO64: result_lo_next = {{48{in_lo[15]}}, in_lo[15:0]};
      KIND_16UTO32, KIND_16UTO64, KIND_32TO16, KIND_64TO16:
        result_lo_next = {48'd0, in_lo[15:0]};
      KIND_32STO64: result_lo_next = {{32{in_lo[31]}}, in_lo[31:0]};
      KIND_32UTO64, KIND_64TO32, KIND_V128TO32, KIND_32UTOV128:
        result_lo_next = {32'd0, in_lo[31:0]};
      KIND_V128TO64, KIND_128TO64, KIND_64UTOV128:
        result_lo_next = in_lo;
      KIND_16HITO8:  result_lo_next = {56'd0, in_lo[15:8]};
      KIND_32HITO16: result_lo_next = {48'd0, in_lo[31:16]};
      KIND_64HITO32: result_lo_next = {32'd0, in_lo[63:32]};
      KIND_128HITO64, KIND_V128HITO64: result_lo_next = in_hi;
      KIND_CLZ32: result_lo_next = {57'd0, clz32_cnt};
      KIND_CLZ64: result_lo_next = {57'd0, clz64_cnt};
      KIND_CTZ32: result_lo_next = {57'd0, ctz32_cnt};
      KIND_CTZ64: result_lo_next = {57'd0, ctz64_cnt};
      KIND_GET_MSBS8X16: result_lo_next = {48'd0, msbs};
      default: unsupported_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
    in_kind     <= kind;
    in_lo       <= operand_lo;
    in_hi       <= operand_hi;
    result_lo   <= result_lo_next;
    result_hi   <= result_hi_next;
    unsupported <= unsupported_next;
  end

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    start |=> in_valid ##1 done)
    else $error("request did not produce a result two cycles later");

  a_unsupported_zero: assert property (@(posedge clk) disable iff (rst)
    done && unsupported |-> result_lo == '0 && result_hi == '0)
    else $error("unsupported result carries data");

  a_hi_only_v128_not: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_kind != KIND_NOTV128 |=> result_hi == '0)
    else $error("upper result half set by a narrow operation");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_kind == KIND_CLZ64 || in_kind == KIND_CTZ64)
    |=> result_lo <= 64'd64)
    else $error("zero count exceeds operand width");

endmodule

`default_nettype wire
